[rtl/core/fowts_pkg.sv]
// Shared types, constants and sprite tables of the fog-of-war tile selector.
// No dependencies; every other file imports this package.
package fowts_pkg;

  localparam int MAX_DIM    = 256;
  localparam int MASK_BYTES = 8192;

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int COORD_W = 8;
  localparam int BADDR_W = 13;
  localparam int DATA_W  = 8;
  localparam int BYTE_AW = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [1:0] FUNC_WR_EXP = 2'd0;
  localparam logic [1:0] FUNC_WR_VIS = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  localparam logic KIND_BLACK  = 1'b0;
  localparam logic KIND_SPRITE = 1'b1;

  localparam logic [4:0] SPRITE_OFFSET = 5'd16;
  localparam logic [3:0] FULL_MASK     = 4'd15;

  typedef struct packed {
    logic [1:0]         func;
    logic [BADDR_W-1:0] addr;
    logic [DATA_W-1:0]  data;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] sprite;
    logic       last;
  } res_t;

  // First sprite of an edge mask (up 1, left 2, down 4, right 8).
  function automatic logic [4:0] first_sprite(input logic [3:0] m);
    case (m)
      4'd5:    return 5'd1;
      4'd7:    return 5'd3;
      4'd10:   return 5'd2;
      4'd11:   return 5'd3;
      4'd13:   return 5'd9;
      4'd14:   return 5'd6;
      4'd15:   return 5'd0;
      default: return {1'b0, m};
    endcase
  endfunction

  // Second sprite of an edge mask; zero when the mask needs one sprite only.
  function automatic logic [4:0] second_sprite(input logic [3:0] m);
    case (m)
      4'd5:    return 5'd4;
      4'd7:    return 5'd6;
      4'd10:   return 5'd8;
      4'd11:   return 5'd9;
      4'd13:   return 5'd12;
      4'd14:   return 5'd12;
      default: return 5'd0;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    else if (32'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    else return DIM_W'(v);
  endfunction

endpackage

[rtl/core/fowts_front.sv]
// Front end: accepts input items, drops undefined functions, and queues
// the rest for the back end. Depends on fowts_pkg.
module fowts_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   func,
  input  logic [fowts_pkg::BADDR_W-1:0] byte_addr,
  input  logic [fowts_pkg::DATA_W-1:0]  byte_data,
  input  logic [fowts_pkg::COORD_W-1:0] cell_x,
  input  logic [fowts_pkg::COORD_W-1:0] cell_y,
  output logic                         cmd_valid,
  output fowts_pkg::cmd_t              cmd,
  input  logic                         cmd_pop
);
  import fowts_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       keep;
  logic       enq;
  logic       deq;

  always_comb begin
    unique case (func) inside
      FUNC_WR_EXP, FUNC_WR_VIS, FUNC_QUERY: keep = 1'b1;
      default:                              keep = 1'b0;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign enq       = push && !full && keep;
  assign deq       = cmd_valid && cmd_pop;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= '{func: func, addr: byte_addr, data: byte_data, x: cell_x, y: cell_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) wp <= ~wp;
      if (deq) rp <= ~rp;
      cnt <= cnt + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

[rtl/core/fowts_back.sv]
// Back end: holds both bitmaps, applies byte writes, reads the five cells
// of a query one per cycle and builds its draw commands. Depends on fowts_pkg.
module fowts_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fowts_pkg::DIM_W-1:0]  map_width,
  input  logic [fowts_pkg::DIM_W-1:0]  map_height,
  input  logic                         cmd_valid,
  input  fowts_pkg::cmd_t              cmd,
  output logic                         cmd_pop,
  output logic                         res_push,
  output fowts_pkg::res_t              res,
  input  logic                         res_full
);
  import fowts_pkg::*;

  localparam int NW = ((DIM_W > COORD_W) ? DIM_W : COORD_W) + 2;
  localparam int IW = 2 * NW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_BUILD = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [2:0] NB_CENTER = 3'd0;
  localparam logic [2:0] NB_UP     = 3'd1;
  localparam logic [2:0] NB_LEFT   = 3'd2;
  localparam logic [2:0] NB_DOWN   = 3'd3;
  localparam logic [2:0] NB_RIGHT  = 3'd4;

  logic [2:0]        state;
  cmd_t              cur;
  logic [2:0]        k;
  logic [4:0]        exp_bits;
  logic [4:0]        vis_bits;
  res_t              lst_q [4];
  logic [2:0]        n_q;
  logic [1:0]        e;

  logic [DATA_W-1:0] mem_exp [MASK_BYTES];
  logic [DATA_W-1:0] mem_vis [MASK_BYTES];
  logic [DATA_W-1:0] rdat_exp;
  logic [DATA_W-1:0] rdat_vis;

  logic              rd_valid;
  logic [2:0]        rd_k;
  logic [2:0]        rd_sel;
  logic              rd_in;
  logic              rd_out;

  logic signed [NW-1:0] dx;
  logic signed [NW-1:0] dy;
  logic signed [NW-1:0] nx;
  logic signed [NW-1:0] ny;
  logic                 outside;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        byte_idx;
  logic                 in_store;
  logic [BYTE_AW-1:0]   rd_addr;

  logic                 wr_ok;
  logic                 wr_exp;
  logic                 wr_vis;
  logic [BYTE_AW-1:0]   wr_addr;

  res_t                 lst [4];
  logic [2:0]           n;
  logic                 stop;
  logic [3:0]           me;
  logic [3:0]           mv;

  assign cmd_pop = (state == S_IDLE);

  // Writes
  assign wr_ok   = (32'(cmd.addr) < MASK_BYTES);
  assign wr_addr = BYTE_AW'(cmd.addr);
  assign wr_exp  = cmd_pop && cmd_valid && (cmd.func == FUNC_WR_EXP) && wr_ok;
  assign wr_vis  = cmd_pop && cmd_valid && (cmd.func == FUNC_WR_VIS) && wr_ok;

  // Neighbor address for the current read step
  always_comb begin
    unique case (k)
      NB_CENTER: begin dx = '0;          dy = '0;          end
      NB_UP:     begin dx = '0;          dy = -NW'(1);     end
      NB_LEFT:   begin dx = -NW'(1);     dy = '0;          end
      NB_DOWN:   begin dx = '0;          dy = NW'(1);      end
      NB_RIGHT:  begin dx = NW'(1);      dy = '0;          end
      default:   begin dx = '0;          dy = '0;          end
    endcase
  end

  assign nx = $signed(NW'(cur.x)) + dx;
  assign ny = $signed(NW'(cur.y)) + dy;
  assign outside = (nx < 0) || (ny < 0) ||
                   (nx >= $signed(NW'(map_width))) || (ny >= $signed(NW'(map_height)));
  assign idx = IW'(map_width) * IW'(nx[NW-2:0] & '0 | ny[NW-2:0]) + IW'(nx[NW-2:0]);
  assign byte_idx = idx >> 3;
  assign in_store = (byte_idx < IW'(MASK_BYTES));
  assign rd_addr  = BYTE_AW'(byte_idx);

  always_ff @(posedge clk) begin
    if (wr_exp) mem_exp[wr_addr] <= cmd.data;
    rdat_exp <= mem_exp[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_vis) mem_vis[wr_addr] <= cmd.data;
    rdat_vis <= mem_vis[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_k   <= k;
    rd_sel <= idx[2:0];
    rd_in  <= in_store;
    rd_out <= outside;
    if (rd_valid) begin
      exp_bits[rd_k] <= rd_out | (rd_in & rdat_exp[rd_sel]);
      vis_bits[rd_k] <= rd_out | (rd_in & rdat_vis[rd_sel]);
    end
  end

  // Draw command list from the ten gathered bits
  always_comb begin
    for (int i = 0; i < 4; i++) lst[i] = '0;
    n    = 3'd0;
    stop = 1'b0;
    me   = ~exp_bits[4:1];
    mv   = ~vis_bits[4:1];
    if (!exp_bits[0]) begin
      lst[0] = '{kind: KIND_BLACK, sprite: 5'd0, last: 1'b0};
      n      = 3'd1;
      stop   = 1'b1;
    end else if (me == FULL_MASK) begin
      lst[0] = '{kind: KIND_BLACK, sprite: 5'd0, last: 1'b0};
      n      = 3'd1;
    end else if (me != 4'd0) begin
      lst[0] = '{kind: KIND_SPRITE, sprite: first_sprite(me), last: 1'b0};
      n      = 3'd1;
      if (second_sprite(me) != 5'd0) begin
        lst[1] = '{kind: KIND_SPRITE, sprite: second_sprite(me), last: 1'b0};
        n      = 3'd2;
      end
    end
    if (!stop) begin
      if (!vis_bits[0] || (mv == FULL_MASK)) begin
        lst[n[1:0]] = '{kind: KIND_SPRITE, sprite: SPRITE_OFFSET, last: 1'b0};
        n = n + 3'd1;
      end else if (mv != 4'd0) begin
        lst[n[1:0]] = '{kind: KIND_SPRITE, sprite: SPRITE_OFFSET + first_sprite(mv),
                        last: 1'b0};
        n = n + 3'd1;
        if (second_sprite(mv) != 5'd0) begin
          lst[n[1:0]] = '{kind: KIND_SPRITE, sprite: SPRITE_OFFSET + second_sprite(mv),
                          last: 1'b0};
          n = n + 3'd1;
        end
      end
    end
    if (n != 3'd0) lst[2'(n - 3'd1)].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == S_BUILD) begin
      for (int i = 0; i < 4; i++) lst_q[i] <= lst[i];
      n_q <= n;
    end
    if (cmd_pop && cmd_valid) cur <= cmd;
  end

  assign res      = lst_q[e];
  assign res_push = (state == S_EMIT) && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      k        <= 3'd0;
      e        <= 2'd0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_READ);
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && (cmd.func == FUNC_QUERY)) begin
            k     <= NB_CENTER;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (k == NB_RIGHT) state <= S_LAST;
          else k <= k + 3'd1;
        end
        S_LAST: begin
          state <= S_BUILD;
        end
        S_BUILD: begin
          e <= 2'd0;
          // drop queries that draw nothing
          state <= (n == 3'd0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (res_push) begin
            if ({1'b0, e} == n_q - 3'd1) state <= S_IDLE;
            else e <= e + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/fowts_resq.sv]
// Result queue: four draw commands between the back end and the result
// ports; the head entry drives the outputs. Depends on fowts_pkg.
module fowts_resq (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_push,
  input  fowts_pkg::res_t res,
  output logic            res_full,
  input  logic            pop,
  output logic            empty,
  output fowts_pkg::res_t head
);
  import fowts_pkg::*;

  res_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       enq;
  logic       deq;

  assign res_full = (cnt == 3'd4);
  assign empty    = (cnt == 3'd0);
  assign head     = q[rp];
  assign enq      = res_push && !res_full;
  assign deq      = pop && !empty;

  always_ff @(posedge clk) begin
    if (enq) q[wp] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (enq) wp <= wp + 2'd1;
      if (deq) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, enq} - {2'b0, deq};
    end
  end

endmodule

[rtl/core/fog_of_war_tile_selector_top.sv]
// A write waits in the front-end queue and is written into its bitmap once it is at
// the queue head while the back end is idle. One write per cycle when no query is in
// the back end; a query holds the back end for five sequential cell reads through the
// single read port of each bitmap memory, then builds its draw commands and emits
// them into the result queue, waiting while that queue is full.
// Reset clears queues, sequencer and map size (1 x 1); bitmaps keep their contents.
module fog_of_war_tile_selector_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        func,
  input  logic [fowts_pkg::BADDR_W-1:0]     byte_addr,
  input  logic [fowts_pkg::DATA_W-1:0]      byte_data,
  input  logic [fowts_pkg::COORD_W-1:0]     cell_x,
  input  logic [fowts_pkg::COORD_W-1:0]     cell_y,
  output logic                              empty,
  input  logic                              pop,
  output logic                              draw_kind,
  output logic [4:0]                        sprite_index,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fowts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fowts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fowts_pkg::*;

  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             res_push;
  res_t             res;
  logic             res_full;
  res_t             head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_W'(1);
      map_height <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= clamp_dim(cfg_data);
        REG_MAP_HEIGHT: map_height <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  fowts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .byte_addr (byte_addr),
    .byte_data (byte_data),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fowts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .map_width  (map_width),
    .map_height (map_height),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  fowts_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign draw_kind    = head.kind;
  assign sprite_index = head.sprite;
  assign last         = head.last;

endmodule

[rtl/core/fowts_checker.sv]
// Port-level checks of the fog-of-war tile selector, bound to the top level.
// Depends on fowts_pkg and fog_of_war_tile_selector_top.
module fowts_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       draw_kind,
  input logic [4:0] sprite_index,
  input logic       last
);
  import fowts_pkg::*;

  // Reset leaves both queues drained
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  a_black_no_sprite: assert property (@(posedge clk) disable iff (rst)
    (!empty && draw_kind == KIND_BLACK) |-> sprite_index == 5'd0)
    else $error("black rectangle carries a sprite number");

  a_sprite_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && draw_kind == KIND_SPRITE) |-> sprite_index != 5'd0)
    else $error("fog sprite with number zero");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting item dropped");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(draw_kind) && $stable(sprite_index) && $stable(last))
    else $error("waiting item changed");

endmodule

bind fog_of_war_tile_selector_top fowts_checker u_fowts_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .draw_kind    (draw_kind),
  .sprite_index (sprite_index),
  .last         (last)
);
